### hw/rtl/gdb_pkg.sv
package gdb_pkg;

  // Vertex slots held by the engine; vertex ids are four bits wide.
  localparam int SLOTS = 16;
  localparam int VID_W = 4;
  localparam int CNT_W = 5;
  localparam int NT_DEPTH = SLOTS * SLOTS;

  typedef logic [VID_W-1:0] vid_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SLOTS-1:0] vmask_t;

  // Command codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_ADD_VERTEX = 3'd1,
    MODE_ADD_EDGE = 3'd2,
    MODE_DEPTH = 3'd3,
    MODE_BREADTH = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK = 2'd0,
    STAT_NOT_CREATED = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_EDGE_B,
    S_EDGE_APP,
    S_RESP,
    S_LOOP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FINISH
  } state_t;

  // One result word on its way to the output register.
  typedef struct packed {
    vid_t visited_vertex;
    logic [1:0] status;
    logic last;
  } res_t;

endpackage

### hw/rtl/gdb_in_if.sv
interface gdb_in_if;
  logic valid;
  logic ready;
  logic [2:0] mode;
  logic [3:0] first_vertex;
  logic [3:0] second_vertex;

  modport source (output valid, output mode, output first_vertex, output second_vertex,
                  input ready);
  modport sink (input valid, input mode, input first_vertex, input second_vertex,
                output ready);
endinterface

### hw/rtl/gdb_out_if.sv
interface gdb_out_if;
  logic valid;
  logic ready;
  logic [3:0] visited_vertex;
  logic [1:0] status;
  logic last;

  modport source (output valid, output visited_vertex, output status, output last,
                  input ready);
  modport sink (input valid, input visited_vertex, input status, input last,
                output ready);
endinterface

### hw/rtl/gdb_ram.sv
module gdb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/gdb_ctrl.sv
module gdb_ctrl #(
  parameter int VERTICES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_mode,
  input  gdb_pkg::vid_t          in_first,
  input  gdb_pkg::vid_t          in_second,
  output logic                   res_valid,
  input  logic                   res_ready,
  output gdb_pkg::res_t          res_data
);

  localparam int AW = $clog2(gdb_pkg::NT_DEPTH);

  gdb_pkg::state_t state_r, state_nxt;
  gdb_pkg::mode_t  mode_r, mode_nxt;
  gdb_pkg::vid_t   a_r, a_nxt, b_r, b_nxt;
  gdb_pkg::vmask_t created_r, created_nxt;
  gdb_pkg::vmask_t visited_r, visited_nxt;
  gdb_pkg::vmask_t rows_r [gdb_pkg::SLOTS];
  gdb_pkg::vmask_t rows_nxt [gdb_pkg::SLOTS];
  gdb_pkg::cnt_t   cnt_r [gdb_pkg::SLOTS];
  gdb_pkg::cnt_t   cnt_nxt [gdb_pkg::SLOTS];
  gdb_pkg::vid_t   store_r [gdb_pkg::SLOTS];
  gdb_pkg::vid_t   store_nxt [gdb_pkg::SLOTS];
  gdb_pkg::cnt_t   head_r, head_nxt, tail_r, tail_nxt;
  gdb_pkg::vid_t   v_r, v_nxt, pend_r, pend_nxt;
  gdb_pkg::cnt_t   c_r, c_nxt, i_r, i_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic            ab_r, ab_nxt, ba_r, ba_nxt;
  logic [1:0]      status_r, status_nxt;

  gdb_pkg::vid_t   row_ra, cnt_ra, st_ra;
  gdb_pkg::vmask_t row_rd;
  gdb_pkg::cnt_t   cnt_rd;
  gdb_pkg::vid_t   st_rd;
  gdb_pkg::cnt_t   tail_m1;
  gdb_pkg::vid_t   u;
  logic            u_new, loop_more, is_dfs, go, ex_a, ex_b, scan_done;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  gdb_pkg::vid_t   ram_wdata;

  // Neighbour lists, one row of SLOTS entries for each vertex.
  gdb_ram #(.WIDTH(gdb_pkg::VID_W), .DEPTH(gdb_pkg::NT_DEPTH)) u_ntab (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(u)
  );

  // Shared lookups and conditions.
  assign row_rd    = rows_r[row_ra];
  assign cnt_rd    = cnt_r[cnt_ra];
  assign st_rd     = store_r[st_ra];
  assign tail_m1   = tail_r - gdb_pkg::CNT_W'(1);
  assign is_dfs    = (mode_r == gdb_pkg::MODE_DEPTH);
  assign u_new     = !visited_r[u];
  assign ex_a      = created_r[a_r];
  assign ex_b      = created_r[b_r];
  assign scan_done = (i_r >= c_r);
  assign loop_more = is_dfs ? (tail_r != '0)
                            : ((head_r < tail_r) && (head_r < gdb_pkg::CNT_W'(gdb_pkg::SLOTS)));
  assign go        = !res_valid || res_ready;

  // Outputs and read addresses for each state.
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res_data  = '0;
    row_ra    = a_r;
    cnt_ra    = a_r;
    st_ra     = is_dfs ? tail_m1[gdb_pkg::VID_W-1:0] : head_r[gdb_pkg::VID_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = {a_r, cnt_rd[gdb_pkg::VID_W-1:0]};
    ram_wdata = b_r;
    ram_re    = 1'b0;
    ram_raddr = {v_r, i_r[gdb_pkg::VID_W-1:0]};
    case (state_r)
      gdb_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      gdb_pkg::S_EDGE_B: begin
        row_ra = b_r;
        ram_we = !(ab_r && row_rd[a_r]) && !ab_r
                 && (cnt_rd < gdb_pkg::CNT_W'(gdb_pkg::SLOTS));
      end
      gdb_pkg::S_EDGE_APP: begin
        cnt_ra    = b_r;
        ram_waddr = {b_r, cnt_rd[gdb_pkg::VID_W-1:0]};
        ram_wdata = a_r;
        ram_we    = !ba_r && (cnt_rd < gdb_pkg::CNT_W'(gdb_pkg::SLOTS));
      end
      gdb_pkg::S_RESP: begin
        res_valid = 1'b1;
        res_data  = '{visited_vertex: '0, status: status_r, last: 1'b1};
      end
      gdb_pkg::S_LOOP: begin
        cnt_ra    = st_rd;
        res_valid = !is_dfs && loop_more && pend_valid_r;
        res_data  = '{visited_vertex: pend_r, status: gdb_pkg::STAT_OK, last: 1'b0};
      end
      gdb_pkg::S_SCAN_RD: begin
        ram_re = !scan_done;
      end
      gdb_pkg::S_SCAN_CHK: begin
        res_valid = is_dfs && u_new && pend_valid_r;
        res_data  = '{visited_vertex: pend_r, status: gdb_pkg::STAT_OK, last: 1'b0};
      end
      gdb_pkg::S_FINISH: begin
        res_valid = 1'b1;
        res_data  = '{visited_vertex: pend_r, status: gdb_pkg::STAT_OK, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdb_pkg::S_IDLE: begin
        if (in_valid) state_nxt = gdb_pkg::S_CMD;
      end
      gdb_pkg::S_CMD: begin
        case (mode_r)
          gdb_pkg::MODE_CLEAR, gdb_pkg::MODE_ADD_VERTEX: state_nxt = gdb_pkg::S_RESP;
          gdb_pkg::MODE_ADD_EDGE: begin
            state_nxt = (!ex_a || !ex_b || (a_r == b_r)) ? gdb_pkg::S_RESP : gdb_pkg::S_EDGE_B;
          end
          gdb_pkg::MODE_DEPTH, gdb_pkg::MODE_BREADTH: begin
            state_nxt = ex_a ? gdb_pkg::S_LOOP : gdb_pkg::S_RESP;
          end
          default: state_nxt = gdb_pkg::S_IDLE;
        endcase
      end
      gdb_pkg::S_EDGE_B: begin
        state_nxt = (ab_r && row_rd[a_r]) ? gdb_pkg::S_RESP : gdb_pkg::S_EDGE_APP;
      end
      gdb_pkg::S_EDGE_APP: state_nxt = gdb_pkg::S_RESP;
      gdb_pkg::S_RESP: begin
        if (go) state_nxt = gdb_pkg::S_IDLE;
      end
      gdb_pkg::S_LOOP: begin
        if (!loop_more) state_nxt = gdb_pkg::S_FINISH;
        else if (go) state_nxt = gdb_pkg::S_SCAN_RD;
      end
      gdb_pkg::S_SCAN_RD: begin
        state_nxt = scan_done ? gdb_pkg::S_LOOP : gdb_pkg::S_SCAN_CHK;
      end
      gdb_pkg::S_SCAN_CHK: begin
        if (is_dfs && u_new) begin
          if (go) state_nxt = gdb_pkg::S_LOOP;
        end else begin
          state_nxt = gdb_pkg::S_SCAN_RD;
        end
      end
      gdb_pkg::S_FINISH: begin
        if (go) state_nxt = gdb_pkg::S_IDLE;
      end
      default: state_nxt = gdb_pkg::S_IDLE;
    endcase
  end

  // Graph, search store and working registers.
  always_comb begin
    mode_nxt       = mode_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    created_nxt    = created_r;
    visited_nxt    = visited_r;
    rows_nxt       = rows_r;
    cnt_nxt        = cnt_r;
    store_nxt      = store_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    v_nxt          = v_r;
    c_nxt          = c_r;
    i_nxt          = i_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    ab_nxt         = ab_r;
    ba_nxt         = ba_r;
    status_nxt     = status_r;
    case (state_r)
      gdb_pkg::S_IDLE: begin
        if (in_valid) begin
          mode_nxt = gdb_pkg::mode_t'(in_mode);
          a_nxt    = in_first;
          b_nxt    = in_second;
        end
      end
      gdb_pkg::S_CMD: begin
        status_nxt = gdb_pkg::STAT_OK;
        case (mode_r)
          gdb_pkg::MODE_CLEAR: begin
            created_nxt = '0;
            for (int k = 0; k < gdb_pkg::SLOTS; k++) begin
              rows_nxt[k] = '0;
              cnt_nxt[k]  = '0;
            end
          end
          gdb_pkg::MODE_ADD_VERTEX: begin
            if (int'(a_r) >= VERTICES) begin
              status_nxt = gdb_pkg::STAT_NOT_CREATED;
            end else begin
              created_nxt[a_r] = 1'b1;
              rows_nxt[a_r]    = '0;
              cnt_nxt[a_r]     = '0;
            end
          end
          gdb_pkg::MODE_ADD_EDGE: begin
            if (!ex_a || !ex_b) status_nxt = gdb_pkg::STAT_NOT_CREATED;
            else if (a_r == b_r) status_nxt = gdb_pkg::STAT_IGNORED;
            ab_nxt = row_rd[b_r];
          end
          gdb_pkg::MODE_DEPTH, gdb_pkg::MODE_BREADTH: begin
            if (!ex_a) begin
              status_nxt = gdb_pkg::STAT_NOT_CREATED;
            end else begin
              visited_nxt      = '0;
              visited_nxt[a_r] = 1'b1;
              store_nxt[0]     = a_r;
              head_nxt         = '0;
              tail_nxt         = gdb_pkg::CNT_W'(1);
              pend_nxt         = a_r;
              pend_valid_nxt   = is_dfs;
            end
          end
          default: begin
          end
        endcase
      end
      gdb_pkg::S_EDGE_B: begin
        ba_nxt = row_rd[a_r];
        if (ab_r && row_rd[a_r]) begin
          status_nxt = gdb_pkg::STAT_IGNORED;
        end else if (!ab_r && (cnt_rd < gdb_pkg::CNT_W'(gdb_pkg::SLOTS))) begin
          cnt_nxt[a_r]       = cnt_rd + gdb_pkg::CNT_W'(1);
          rows_nxt[a_r][b_r] = 1'b1;
        end
      end
      gdb_pkg::S_EDGE_APP: begin
        if (!ba_r && (cnt_rd < gdb_pkg::CNT_W'(gdb_pkg::SLOTS))) begin
          cnt_nxt[b_r]       = cnt_rd + gdb_pkg::CNT_W'(1);
          rows_nxt[b_r][a_r] = 1'b1;
        end
      end
      gdb_pkg::S_LOOP: begin
        if (loop_more && go) begin
          v_nxt = st_rd;
          c_nxt = cnt_rd;
          i_nxt = '0;
          if (!is_dfs) begin
            head_nxt       = head_r + gdb_pkg::CNT_W'(1);
            pend_nxt       = st_rd;
            pend_valid_nxt = 1'b1;
          end
        end
      end
      gdb_pkg::S_SCAN_RD: begin
        if (scan_done && is_dfs) tail_nxt = tail_m1;
      end
      gdb_pkg::S_SCAN_CHK: begin
        if (u_new) begin
          if (go) begin
            visited_nxt[u] = 1'b1;
            if (is_dfs) pend_nxt = u;
            if (tail_r < gdb_pkg::CNT_W'(gdb_pkg::SLOTS)) begin
              store_nxt[tail_r[gdb_pkg::VID_W-1:0]] = u;
              tail_nxt = tail_r + gdb_pkg::CNT_W'(1);
            end
            if (!is_dfs) i_nxt = i_r + gdb_pkg::CNT_W'(1);
          end
        end else begin
          i_nxt = i_r + gdb_pkg::CNT_W'(1);
        end
      end
      gdb_pkg::S_FINISH: begin
        if (go) pend_valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gdb_pkg::S_IDLE;
      created_r    <= '0;
      visited_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      pend_valid_r <= 1'b0;
      for (int k = 0; k < gdb_pkg::SLOTS; k++) begin
        rows_r[k] <= '0;
        cnt_r[k]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      created_r    <= created_nxt;
      visited_r    <= visited_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      pend_valid_r <= pend_valid_nxt;
      rows_r       <= rows_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    store_r  <= store_nxt;
    v_r      <= v_nxt;
    c_r      <= c_nxt;
    i_r      <= i_nxt;
    pend_r   <= pend_nxt;
    ab_r     <= ab_nxt;
    ba_r     <= ba_nxt;
    status_r <= status_nxt;
  end

endmodule

### hw/rtl/graph_dfs_bfs_engine.sv
// Channel   Dir  Word                                        Accepted when
// in_chan   in   mode[3], first_vertex[4], second_vertex[4]  valid && ready
// out_chan  out  visited_vertex[4], status[2], last[1]       valid && ready
//
// A command runs S_CMD, S_EDGE_B and S_EDGE_APP for a new edge, then S_RESP, which
// hands the status word to the output register; a new word is taken the cycle after.
// A search reads and checks each neighbour-list entry in turn (registered read of the
// neighbour table), rescanning lists from the start for depth first.
// Reset (rst_n low, synchronous) empties the graph at once; no clearing pass.
// Input is taken only when the sequencer is idle; a full output register stalls it.
module graph_dfs_bfs_engine #(
  parameter int VERTICES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  gdb_in_if.sink    in_chan,
  gdb_out_if.source out_chan
);

  logic          res_valid, res_ready, out_valid_r, out_valid_nxt;
  gdb_pkg::res_t res_data, out_data_r;

  gdb_ctrl #(.VERTICES(VERTICES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_mode  (in_chan.mode),
    .in_first (in_chan.first_vertex),
    .in_second(in_chan.second_vertex),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  // Output register: takes a new word whenever it is empty or being drained.
  assign res_ready     = !out_valid_r || out_chan.ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.visited_vertex = out_data_r.visited_vertex;
  assign out_chan.status         = out_data_r.status;
  assign out_chan.last           = out_data_r.last;

endmodule

### sim/graph_dfs_bfs_engine_tb.sv
module graph_dfs_bfs_engine_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gdb_in_if in_if ();
  gdb_out_if out_if ();

  graph_dfs_bfs_engine u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_if),
    .out_chan(out_if)
  );

  always #2 clk = ~clk;

  // Shadow copy of the graph held by the engine.
  gdb_pkg::vmask_t g_created;
  gdb_pkg::vmask_t g_adj [gdb_pkg::SLOTS];
  gdb_pkg::vid_t g_nbr [gdb_pkg::SLOTS][gdb_pkg::SLOTS];
  int g_cnt [gdb_pkg::SLOTS];

  gdb_pkg::res_t expected_words [$];
  int errors = 0;
  int words_checked = 0;
  int items_sent = 0;
  int searches_sent = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.first_vertex = '0;
    in_if.second_vertex = '0;
    out_if.ready = 1'b0;
  end

  function automatic void graph_clear();
    g_created = '0;
    for (int i = 0; i < gdb_pkg::SLOTS; i++) begin
      g_adj[i] = '0;
      g_cnt[i] = 0;
    end
  endfunction

  function automatic void expect_status(gdb_pkg::status_t st);
    gdb_pkg::res_t r;
    r.visited_vertex = '0;
    r.status = st;
    r.last = 1'b1;
    expected_words.push_back(r);
  endfunction

  function automatic void append_nbr(gdb_pkg::vid_t v, gdb_pkg::vid_t u);
    if (g_cnt[v] < gdb_pkg::SLOTS) begin
      g_nbr[v][g_cnt[v]] = u;
      g_cnt[v]++;
      g_adj[v][u] = 1'b1;
    end
  endfunction

  // Visit order of an iterative depth first or breadth first search.
  function automatic void predict_search(bit depth, gdb_pkg::vid_t start);
    gdb_pkg::vid_t order [$];
    gdb_pkg::vid_t work [$];
    gdb_pkg::vmask_t seen;
    gdb_pkg::vid_t v;
    gdb_pkg::vid_t u;
    bit found;
    gdb_pkg::res_t r;
    seen = '0;
    seen[start] = 1'b1;
    work.push_back(start);
    if (depth) begin
      order.push_back(start);
      while (work.size() > 0) begin
        v = work[$];
        found = 1'b0;
        for (int i = 0; i < g_cnt[v] && !found; i++) begin
          u = g_nbr[v][i];
          if (!seen[u]) begin
            seen[u] = 1'b1;
            order.push_back(u);
            work.push_back(u);
            found = 1'b1;
          end
        end
        if (!found) void'(work.pop_back());
      end
    end else begin
      while (work.size() > 0) begin
        v = work.pop_front();
        order.push_back(v);
        for (int i = 0; i < g_cnt[v]; i++) begin
          u = g_nbr[v][i];
          if (!seen[u]) begin
            seen[u] = 1'b1;
            work.push_back(u);
          end
        end
      end
    end
    foreach (order[k]) begin
      r.visited_vertex = order[k];
      r.status = gdb_pkg::STAT_OK;
      r.last = (k == order.size() - 1);
      expected_words.push_back(r);
    end
  endfunction

  // Works out the words that one accepted command causes.
  function automatic void predict_command(logic [2:0] m, gdb_pkg::vid_t a, gdb_pkg::vid_t b);
    bit ab;
    bit ba;
    case (m)
      gdb_pkg::MODE_CLEAR: begin
        graph_clear();
        expect_status(gdb_pkg::STAT_OK);
      end
      gdb_pkg::MODE_ADD_VERTEX: begin
        g_created[a] = 1'b1;
        g_adj[a] = '0;
        g_cnt[a] = 0;
        expect_status(gdb_pkg::STAT_OK);
      end
      gdb_pkg::MODE_ADD_EDGE: begin
        if (!g_created[a] || !g_created[b]) begin
          expect_status(gdb_pkg::STAT_NOT_CREATED);
        end else if (a == b) begin
          expect_status(gdb_pkg::STAT_IGNORED);
        end else begin
          ab = g_adj[a][b];
          ba = g_adj[b][a];
          if (ab && ba) begin
            expect_status(gdb_pkg::STAT_IGNORED);
          end else begin
            if (!ab) append_nbr(a, b);
            if (!ba) append_nbr(b, a);
            expect_status(gdb_pkg::STAT_OK);
          end
        end
      end
      gdb_pkg::MODE_DEPTH, gdb_pkg::MODE_BREADTH: begin
        if (!g_created[a]) expect_status(gdb_pkg::STAT_NOT_CREATED);
        else predict_search(m == gdb_pkg::MODE_DEPTH, a);
      end
      default: ;
    endcase
  endfunction

  // Sends one command word; valid is lowered only when a gap follows.
  task automatic send_cmd(logic [2:0] m, gdb_pkg::vid_t a, gdb_pkg::vid_t b);
    while (!calm && $urandom_range(99) < 35) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.first_vertex <= a;
    in_if.second_vertex <= b;
    do @(posedge clk); while (!in_if.ready);
    predict_command(m, a, b);
    items_sent++;
    if (m == gdb_pkg::MODE_DEPTH || m == gdb_pkg::MODE_BREADTH) searches_sent++;
  endtask

  // Result side: random back-pressure and comparison with the oldest expectation.
  always @(posedge clk) begin
    gdb_pkg::res_t want;
    if (rst_n) begin
      out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word vertex=%0d status=%0d last=%0d", $time,
                   out_if.visited_vertex, out_if.status, out_if.last);
          errors++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (out_if.visited_vertex !== want.visited_vertex) begin
            $display("%0t: vertex expected %0d actual %0d", $time,
                     want.visited_vertex, out_if.visited_vertex);
            errors++;
          end
          if (out_if.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_if.status);
            errors++;
          end
          if (out_if.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time,
                     want.last, out_if.last);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Status cases, duplicates, self loops, re-added vertex and unused modes.
  task automatic test_commands();
    send_cmd(gdb_pkg::MODE_CLEAR, 4'd0, 4'd0);
    send_cmd(gdb_pkg::MODE_DEPTH, 4'd3, 4'd0);
    send_cmd(gdb_pkg::MODE_BREADTH, 4'd15, 4'd15);
    send_cmd(gdb_pkg::MODE_ADD_VERTEX, 4'd0, 4'd15);
    send_cmd(gdb_pkg::MODE_ADD_VERTEX, 4'd15, 4'd0);
    send_cmd(gdb_pkg::MODE_ADD_EDGE, 4'd0, 4'd7);
    send_cmd(gdb_pkg::MODE_ADD_EDGE, 4'd15, 4'd15);
    send_cmd(gdb_pkg::MODE_ADD_EDGE, 4'd0, 4'd15);
    send_cmd(gdb_pkg::MODE_ADD_EDGE, 4'd15, 4'd0);
    send_cmd(3'd5, 4'd0, 4'd0);
    send_cmd(3'd6, 4'd15, 4'd15);
    send_cmd(3'd7, 4'd10, 4'd5);
    send_cmd(gdb_pkg::MODE_ADD_VERTEX, 4'd0, 4'd0);
    send_cmd(gdb_pkg::MODE_ADD_EDGE, 4'd15, 4'd0);
    send_cmd(gdb_pkg::MODE_DEPTH, 4'd0, 4'd0);
    send_cmd(gdb_pkg::MODE_BREADTH, 4'd15, 4'd0);
  endtask

  // All sixteen vertices in a chain plus a spoke, so searches give sixteen words.
  task automatic test_full_graph();
    send_cmd(gdb_pkg::MODE_CLEAR, 4'd15, 4'd15);
    for (int v = 0; v < gdb_pkg::SLOTS; v++)
      send_cmd(gdb_pkg::MODE_ADD_VERTEX, gdb_pkg::vid_t'(v), 4'd0);
    for (int v = 0; v < gdb_pkg::SLOTS - 1; v++)
      send_cmd(gdb_pkg::MODE_ADD_EDGE, gdb_pkg::vid_t'(v), gdb_pkg::vid_t'(v + 1));
    send_cmd(gdb_pkg::MODE_ADD_EDGE, 4'd0, 4'd8);
    send_cmd(gdb_pkg::MODE_DEPTH, 4'd0, 4'd0);
    send_cmd(gdb_pkg::MODE_BREADTH, 4'd0, 4'd0);
    send_cmd(gdb_pkg::MODE_DEPTH, 4'd15, 4'd0);
  endtask

  // Random graphs built from scratch, then searched, with some noise mixed in.
  task automatic test_random_graphs();
    int n_vert;
    int n_edge;
    int round;
    round = 0;
    while (items_sent < 105) begin
      calm = (round == 1);
      send_cmd(gdb_pkg::MODE_CLEAR, gdb_pkg::vid_t'($urandom), gdb_pkg::vid_t'($urandom));
      n_vert = $urandom_range(16, 2);
      for (int i = 0; i < n_vert; i++)
        send_cmd(gdb_pkg::MODE_ADD_VERTEX, gdb_pkg::vid_t'($urandom),
                 gdb_pkg::vid_t'($urandom));
      n_edge = $urandom_range(24, 4);
      for (int i = 0; i < n_edge; i++) begin
        case ($urandom_range(9))
          0: send_cmd(3'($urandom_range(7, 5)), gdb_pkg::vid_t'($urandom),
                      gdb_pkg::vid_t'($urandom));
          1: send_cmd(gdb_pkg::MODE_ADD_VERTEX, gdb_pkg::vid_t'($urandom),
                      gdb_pkg::vid_t'($urandom));
          2: send_cmd(gdb_pkg::MODE_DEPTH, gdb_pkg::vid_t'($urandom),
                      gdb_pkg::vid_t'($urandom));
          default: send_cmd(gdb_pkg::MODE_ADD_EDGE, gdb_pkg::vid_t'($urandom),
                            gdb_pkg::vid_t'($urandom));
        endcase
      end
      for (int i = 0; i < 3; i++)
        send_cmd($urandom_range(1) ? gdb_pkg::MODE_DEPTH : gdb_pkg::MODE_BREADTH,
                 gdb_pkg::vid_t'($urandom), gdb_pkg::vid_t'($urandom));
      round++;
    end
    calm = 1'b0;
  endtask

  initial begin
    graph_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_full_graph();
    test_random_graphs();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d commands, %0d of them searches, with %0d result words checked.",
             items_sent, searches_sent, words_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
